>>> hw/rtl/rwhp_pkg.sv
// ----------------------------------------------------------------------------
// rwhp_pkg
// Types and constants shared by the RIFF WAVE header parser modules.
// ----------------------------------------------------------------------------
package rwhp_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;
  localparam logic [31:0] FMT_KEEP = 32'h0000_0012;

  localparam int FMT_BYTES = 18;
  localparam int FMT_IDX_W = $clog2(FMT_BYTES + 1);

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOT_RIFF = 2'd1;
  localparam logic [1:0] ST_NOT_WAVE = 2'd2;
  localparam logic [1:0] ST_SHORT    = 2'd3;

  typedef enum logic [3:0] {
    PH_RIFF,
    PH_RSIZE,
    PH_WAVE,
    PH_FMT_ID,
    PH_FMT_SIZE,
    PH_FMT_DATA,
    PH_CHUNK_TAG,
    PH_CHUNK_SIZE,
    PH_SKIP,
    PH_DATA_SIZE
  } phase_t;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  parse_status;
    logic [31:0] data_size;
    logic [31:0] data_offset;
    logic [15:0] format_tag;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [15:0] block_align;
    logic [15:0] bits_per_sample;
    logic [15:0] extra_size;
  } out_item_t;

endpackage

>>> hw/rtl/riff_wave_header_parser_unit.sv
// ----------------------------------------------------------------------------
// riff_wave_header_parser_unit
// Streams a WAVE file in one byte per transfer and reports the data chunk
// size, its file offset and the format fields, or an error status.
// ----------------------------------------------------------------------------
// One byte is taken every cycle unless the input stalls. The parse state is
// updated by a single pass of logic from the accepted byte into the state
// registers, and a result is registered into the output buffer. A
// result register plus one skid entry sit on the output; the byte input
// stalls only while both hold results.
module riff_wave_header_parser_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rwhp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rwhp_pkg::out_item_t out_data
);
  import rwhp_pkg::*;

  logic      in_fire;
  logic      res_valid;
  out_item_t res_item;
  logic      buf_full;

  assign in_stall = buf_full;
  assign in_fire  = in_valid && !buf_full;

  rwhp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_item   (in_data),
    .res_valid (res_valid),
    .res_item  (res_item)
  );

  rwhp_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (res_valid),
    .push_item  (res_item),
    .full       (buf_full),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

>>> hw/rtl/rwhp_core.sv
// ----------------------------------------------------------------------------
// rwhp_core
// Per-byte parse state machine: word assembly, chunk counting, format capture
// and result formation.
// ----------------------------------------------------------------------------
module rwhp_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  rwhp_pkg::in_item_t  in_item,
  output logic                res_valid,
  output rwhp_pkg::out_item_t res_item
);
  import rwhp_pkg::*;

  phase_t                 phase_r, phase_nxt;
  logic [1:0]             wcnt_r, wcnt_nxt;
  logic [31:0]            word_r, word_nxt;
  logic [31:0]            left_r, left_nxt;
  logic                   fmt_long_r, fmt_long_nxt;
  logic [31:0]            pos_r, pos_nxt;
  logic [FMT_IDX_W-1:0]   fmt_idx_r, fmt_idx_nxt;
  logic                   done_r, done_nxt;
  logic [7:0]             fmt_r [FMT_BYTES];

  logic [31:0] word_in;
  logic        fmt_wr;
  logic        clear;
  logic        emit;
  logic [1:0]  status;
  logic [31:0] size;

  assign word_in = {in_item.stream_byte, word_r[31:8]};

  // next state
  always_comb begin
    phase_nxt    = phase_r;
    wcnt_nxt     = wcnt_r;
    word_nxt     = word_r;
    left_nxt     = left_r;
    fmt_long_nxt = fmt_long_r;
    pos_nxt      = pos_r;
    fmt_idx_nxt  = fmt_idx_r;
    done_nxt     = done_r;
    fmt_wr       = 1'b0;
    clear        = 1'b0;
    emit         = 1'b0;
    status       = ST_OK;
    size         = '0;
    if (in_fire) begin
      if (done_r) begin
        clear = in_item.stream_end;
      end else begin
        pos_nxt = (pos_r == '1) ? pos_r : pos_r + 32'd1;
        if (phase_r == PH_FMT_DATA || phase_r == PH_SKIP) begin
          if (phase_r == PH_FMT_DATA && fmt_idx_r < FMT_IDX_W'(FMT_BYTES)) begin
            fmt_wr      = 1'b1;
            fmt_idx_nxt = fmt_idx_r + FMT_IDX_W'(1);
          end
          left_nxt = left_r - 32'd1;
          if (left_r == 32'd1) begin
            phase_nxt = PH_CHUNK_TAG;
          end
        end else begin
          word_nxt = word_in;
          if (wcnt_r != 2'd3) begin
            wcnt_nxt = wcnt_r + 2'd1;
          end else begin
            wcnt_nxt = 2'd0;
            unique case (phase_r)
              PH_RIFF: begin
                if (word_in != TAG_RIFF) begin
                  emit   = 1'b1;
                  status = ST_NOT_RIFF;
                end else begin
                  phase_nxt = PH_RSIZE;
                end
              end
              PH_RSIZE: phase_nxt = PH_WAVE;
              PH_WAVE: begin
                if (word_in != TAG_WAVE) begin
                  emit   = 1'b1;
                  status = ST_NOT_WAVE;
                end else begin
                  phase_nxt = PH_FMT_ID;
                end
              end
              PH_FMT_ID: phase_nxt = PH_FMT_SIZE;
              PH_FMT_SIZE: begin
                fmt_long_nxt = (word_in > FMT_KEEP);
                left_nxt     = word_in;
                phase_nxt    = (word_in != '0) ? PH_FMT_DATA : PH_CHUNK_TAG;
              end
              PH_CHUNK_TAG: begin
                phase_nxt = (word_in == TAG_DATA) ? PH_DATA_SIZE : PH_CHUNK_SIZE;
              end
              PH_CHUNK_SIZE: begin
                left_nxt  = word_in;
                phase_nxt = (word_in != '0) ? PH_SKIP : PH_CHUNK_TAG;
              end
              PH_DATA_SIZE: begin
                emit = 1'b1;
                size = word_in;
              end
              default: phase_nxt = PH_RIFF;
            endcase
          end
        end
        if (!emit && in_item.stream_end) begin
          emit   = 1'b1;
          status = ST_SHORT;
        end
        if (emit) begin
          if (in_item.stream_end) begin
            clear = 1'b1;
          end else begin
            done_nxt = 1'b1;
          end
        end
      end
    end
  end

  // result
  always_comb begin
    res_valid             = emit;
    res_item              = '0;
    res_item.parse_status = status;
    if (status == ST_OK) begin
      res_item.data_size       = size;
      res_item.data_offset     = pos_nxt;
      res_item.format_tag      = {fmt_r[1], fmt_r[0]};
      res_item.channel_count   = {fmt_r[3], fmt_r[2]};
      res_item.sample_rate     = {fmt_r[7], fmt_r[6], fmt_r[5], fmt_r[4]};
      res_item.byte_rate       = {fmt_r[11], fmt_r[10], fmt_r[9], fmt_r[8]};
      res_item.block_align     = {fmt_r[13], fmt_r[12]};
      res_item.bits_per_sample = {fmt_r[15], fmt_r[14]};
      res_item.extra_size      = fmt_long_r ? {fmt_r[17], fmt_r[16]} : 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      phase_r    <= PH_RIFF;
      wcnt_r     <= '0;
      word_r     <= '0;
      left_r     <= '0;
      fmt_long_r <= 1'b0;
      pos_r      <= '0;
      fmt_idx_r  <= '0;
      done_r     <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      wcnt_r     <= wcnt_nxt;
      word_r     <= word_nxt;
      left_r     <= left_nxt;
      fmt_long_r <= fmt_long_nxt;
      pos_r      <= pos_nxt;
      fmt_idx_r  <= fmt_idx_nxt;
      done_r     <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      for (int i = 0; i < FMT_BYTES; i++) begin
        fmt_r[i] <= '0;
      end
    end else if (fmt_wr) begin
      fmt_r[fmt_idx_r] <= in_item.stream_byte;
    end
  end

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fmt_idx_r <= FMT_IDX_W'(FMT_BYTES))
    else $error("format byte index past capture window");

  a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !res_valid)
    else $error("result while waiting for end of file");

endmodule

>>> hw/rtl/rwhp_outbuf.sv
// ----------------------------------------------------------------------------
// rwhp_outbuf
// Result register with one skid entry; decouples the result channel stall
// from the byte input.
// ----------------------------------------------------------------------------
module rwhp_outbuf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  input  rwhp_pkg::out_item_t push_item,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output rwhp_pkg::out_item_t out_data
);
  import rwhp_pkg::*;

  logic      out_valid_r;
  out_item_t out_data_r;
  logic      skid_valid_r;
  out_item_t skid_data_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign full      = skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_valid_r && !out_stall) begin
      if (skid_valid_r) begin
        out_data_r   <= skid_data_r;
        skid_valid_r <= 1'b0;
      end else if (push_valid) begin
        out_data_r <= push_item;
      end else begin
        out_valid_r <= 1'b0;
      end
    end else if (!out_valid_r) begin
      if (push_valid) begin
        out_data_r  <= push_item;
        out_valid_r <= 1'b1;
      end
    end else if (push_valid) begin
      skid_data_r  <= push_item;
      skid_valid_r <= 1'b1;
    end
  end

  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without a result in front");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(push_valid && skid_valid_r))
    else $error("result pushed into full buffer");

  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_stall) |=> (out_valid_r && !skid_valid_r))
    else $error("skid entry not moved forward on transfer");

endmodule

>>> bench/riff_wave_header_checker.sv
// ----------------------------------------------------------------------------
// riff_wave_header_checker
// Watches both channels of the RIFF WAVE header parser, tracks the parse of
// every accepted byte with its own copy of the parser state and compares each
// result transfer, field by field, with the oldest predicted header report.
// ----------------------------------------------------------------------------
module riff_wave_header_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  rwhp_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  rwhp_pkg::out_item_t out_data,
  output int                  mismatch_count,
  output int                  reports_owed
);
  timeunit 1ns;
  timeprecision 1ps;
  import rwhp_pkg::*;

  phase_t      parse_phase;
  logic [1:0]  word_count;
  logic [31:0] word_shift;
  logic [31:0] chunk_left;
  logic [31:0] fmt_len;
  logic [31:0] file_pos;
  logic [7:0]  fmt_bytes [FMT_BYTES];
  bit          finished;

  out_item_t   owed_reports [$];

  function automatic void clear_parser();
    parse_phase = PH_RIFF;
    word_count  = '0;
    word_shift  = '0;
    chunk_left  = '0;
    fmt_len     = '0;
    file_pos    = '0;
    finished    = 0;
    foreach (fmt_bytes[i]) fmt_bytes[i] = '0;
  endfunction

  function automatic out_item_t make_report(input logic [1:0] status,
                                            input logic [31:0] size);
    out_item_t r;
    r = '0;
    r.parse_status = status;
    if (status == ST_OK) begin
      r.data_size       = size;
      r.data_offset     = file_pos;
      r.format_tag      = {fmt_bytes[1], fmt_bytes[0]};
      r.channel_count   = {fmt_bytes[3], fmt_bytes[2]};
      r.sample_rate     = {fmt_bytes[7], fmt_bytes[6], fmt_bytes[5], fmt_bytes[4]};
      r.byte_rate       = {fmt_bytes[11], fmt_bytes[10], fmt_bytes[9], fmt_bytes[8]};
      r.block_align     = {fmt_bytes[13], fmt_bytes[12]};
      r.bits_per_sample = {fmt_bytes[15], fmt_bytes[14]};
      r.extra_size      = (fmt_len <= FMT_KEEP) ? 16'h0 : {fmt_bytes[17], fmt_bytes[16]};
    end
    return r;
  endfunction

  function automatic bit parse_byte(input in_item_t it, output out_item_t rpt);
    logic [31:0] idx;
    bit          hit;
    hit = 0;
    rpt = '0;
    if (finished) begin
      if (it.stream_end) clear_parser();
      return 0;
    end
    if (file_pos != 32'hFFFF_FFFF) file_pos++;
    if (parse_phase == PH_FMT_DATA || parse_phase == PH_SKIP) begin
      if (parse_phase == PH_FMT_DATA) begin
        idx = fmt_len - chunk_left;
        if (idx < FMT_KEEP) fmt_bytes[idx[FMT_IDX_W-1:0]] = it.stream_byte;
      end
      chunk_left--;
      if (chunk_left == 0) parse_phase = PH_CHUNK_TAG;
    end else begin
      word_shift = {it.stream_byte, word_shift[31:8]};
      if (word_count != 2'd3) begin
        word_count++;
      end else begin
        word_count = '0;
        case (parse_phase)
          PH_RIFF: begin
            if (word_shift != TAG_RIFF) begin
              rpt = make_report(ST_NOT_RIFF, '0);
              hit = 1;
            end else begin
              parse_phase = PH_RSIZE;
            end
          end
          PH_RSIZE: parse_phase = PH_WAVE;
          PH_WAVE: begin
            if (word_shift != TAG_WAVE) begin
              rpt = make_report(ST_NOT_WAVE, '0);
              hit = 1;
            end else begin
              parse_phase = PH_FMT_ID;
            end
          end
          PH_FMT_ID: parse_phase = PH_FMT_SIZE;
          PH_FMT_SIZE: begin
            fmt_len     = word_shift;
            chunk_left  = word_shift;
            parse_phase = (word_shift != 0) ? PH_FMT_DATA : PH_CHUNK_TAG;
          end
          PH_CHUNK_TAG: parse_phase = (word_shift == TAG_DATA) ? PH_DATA_SIZE : PH_CHUNK_SIZE;
          PH_CHUNK_SIZE: begin
            chunk_left  = word_shift;
            parse_phase = (word_shift != 0) ? PH_SKIP : PH_CHUNK_TAG;
          end
          PH_DATA_SIZE: begin
            rpt = make_report(ST_OK, word_shift);
            hit = 1;
          end
          default: parse_phase = PH_RIFF;
        endcase
      end
    end
    if (!hit && it.stream_end) begin
      rpt = make_report(ST_SHORT, '0);
      hit = 1;
    end
    if (hit) begin
      if (it.stream_end) clear_parser();
      else finished = 1;
    end
    return hit;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got, inout bit bad);
    if (got !== want) begin
      if (mismatch_count < 10)
        $display("%0t mismatch %s: expected %h, got %h", $realtime, name, want, got);
      bad = 1;
    end
  endtask

  task automatic compare_report(input out_item_t want, input out_item_t got);
    bit bad;
    bad = 0;
    check_field("parse_status", want.parse_status, got.parse_status, bad);
    check_field("data_size", want.data_size, got.data_size, bad);
    check_field("data_offset", want.data_offset, got.data_offset, bad);
    check_field("format_tag", want.format_tag, got.format_tag, bad);
    check_field("channel_count", want.channel_count, got.channel_count, bad);
    check_field("sample_rate", want.sample_rate, got.sample_rate, bad);
    check_field("byte_rate", want.byte_rate, got.byte_rate, bad);
    check_field("block_align", want.block_align, got.block_align, bad);
    check_field("bits_per_sample", want.bits_per_sample, got.bits_per_sample, bad);
    check_field("extra_size", want.extra_size, got.extra_size, bad);
    if (bad) mismatch_count++;
  endtask

  always @(posedge clk) begin
    out_item_t rpt;
    if (!rst_n) begin
      clear_parser();
      owed_reports.delete();
      mismatch_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_reports.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t unexpected result transfer: %p", $realtime, out_data);
          mismatch_count++;
        end else begin
          compare_report(owed_reports.pop_front(), out_data);
        end
      end
      if (in_valid && !in_stall) begin
        if (parse_byte(in_data, rpt)) owed_reports.push_back(rpt);
      end
    end
    reports_owed = owed_reports.size();
  end

endmodule

>>> bench/tb_riff_wave_header_parser_unit.sv
// ----------------------------------------------------------------------------
// tb_riff_wave_header_parser_unit
// Feeds the header parser with short directed files, then random WAVE files:
// well-formed ones with random format and chunk layouts, truncated ones,
// files with corrupted tags and plain noise, under random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_riff_wave_header_parser_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import rwhp_pkg::*;

  localparam logic [31:0] FMT_ID_TAG = 32'h2074_6D66;
  localparam int BYTE_TARGET = 1700;
  localparam int IDLE_LIMIT  = 1000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  int        mismatch_count;
  int        reports_owed;
  int        idle_cycles;
  int        bytes_sent;
  bit        idle_on;
  logic [7:0] file_q [$];

  riff_wave_header_parser_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  riff_wave_header_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .mismatch_count(mismatch_count),
    .reports_owed  (reports_owed)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // result side: random stall before each transfer
  initial begin
    int n;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      n = idle_on ? $urandom_range(0, 5) : 0;
      if (n > 0) begin
        out_stall = 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!(out_valid === 1'b1 && !out_stall));
      @(negedge clk);
    end
  end

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom());
    endcase
  endfunction

  task automatic put_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) file_q.push_back(w[8*i +: 8]);
  endtask

  task automatic put_rand(input int n);
    repeat (n) file_q.push_back(rand_byte());
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data.stream_byte = b;
    in_data.stream_end  = last;
    do @(posedge clk); while (in_stall !== 1'b0);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_file();
    foreach (file_q[i]) send_byte(file_q[i], i == file_q.size() - 1);
    file_q.delete();
  endtask

  task automatic wait_reports_drained();
    in_valid = 1'b0;
    while (reports_owed != 0) @(negedge clk);
  endtask

  task automatic build_wave();
    int flen;
    int clen;
    put_word(TAG_RIFF);
    put_word($urandom());
    put_word(TAG_WAVE);
    put_word(($urandom_range(0, 3) == 0) ? $urandom() : FMT_ID_TAG);
    case ($urandom_range(0, 6))
      0: flen = 0;
      1: flen = 16;
      2: flen = 18;
      3: flen = 19;
      4: flen = 20;
      default: flen = $urandom_range(1, 40);
    endcase
    put_word(flen);
    put_rand(flen);
    repeat ($urandom_range(0, 2)) begin
      clen = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      put_word($urandom());
      put_word(clen);
      put_rand(clen);
    end
    put_word(TAG_DATA);
    case ($urandom_range(0, 3))
      0: put_word(32'h0);
      1: put_word(32'hFFFF_FFFF);
      default: put_word($urandom());
    endcase
    put_rand($urandom_range(0, 4));
  endtask

  task automatic flip_bit_in(input int lo, input int hi);
    int i;
    i = $urandom_range(lo, hi);
    file_q[i] = file_q[i] ^ (8'h01 << $urandom_range(0, 7));
  endtask

  initial begin
    int cut;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    idle_on     = 1'b1;
    idle_cycles = 0;
    bytes_sent  = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // lone last byte: file ended early
    file_q.push_back(8'hA5);
    send_file();
    // bad RIFF tag on the last byte
    put_word(~TAG_RIFF);
    send_file();
    // bad WAVE form on the last byte
    put_word(TAG_RIFF);
    put_word(32'h0);
    put_word(~TAG_WAVE);
    send_file();
    // empty format and skip chunks, data size ends the file
    put_word(TAG_RIFF);
    put_word(32'hFFFF_FFFF);
    put_word(TAG_WAVE);
    put_word(FMT_ID_TAG);
    put_word(32'h0);
    put_word(32'h0);
    put_word(32'h0);
    put_word(TAG_DATA);
    put_word(32'hFFFF_FFFF);
    send_file();
    wait_reports_drained();

    while (bytes_sent < BYTE_TARGET) begin
      idle_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        6: begin
          build_wave();
          cut = $urandom_range(1, file_q.size() - 1);
          while (file_q.size() > cut) void'(file_q.pop_back());
        end
        7: begin
          build_wave();
          flip_bit_in(0, 3);
        end
        8: begin
          build_wave();
          flip_bit_in(8, 11);
        end
        9: put_rand($urandom_range(1, 12));
        default: build_wave();
      endcase
      send_file();
      if ($urandom_range(0, 7) == 0) wait_reports_drained();
    end

    in_valid = 1'b0;
    while (reports_owed != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && reports_owed == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
